// File: hdl/imhq_pkg.sv
package imhq_pkg;

    localparam int ID_W       = 6;
    localparam int ID_COUNT   = 64;
    localparam int CAP_W      = 7;
    localparam int CNT_OUT_W  = 7;
    localparam int EXT_PRIO_W = 32;
    localparam int DEF_DEPTH  = 64;
    localparam int DEF_PRIO_W = 32;
    localparam int CAP_RESET  = 64;

    typedef enum logic [1:0] {
        ACT_PUSH   = 2'd0,
        ACT_POP    = 2'd1,
        ACT_UPDATE = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        STAT_OK      = 3'd0,
        STAT_FULL    = 3'd1,
        STAT_EMPTY   = 3'd2,
        STAT_MISSING = 3'd3,
        STAT_DUP     = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_POP0,
        S_POP1,
        S_UPD0,
        S_UPD1,
        S_UP,
        S_UP_CMP,
        S_DN,
        S_DN_L,
        S_DN_R,
        S_PLACE,
        S_DONE
    } t_state;

endpackage

// File: hdl/imhq_if.sv
interface imhq_req_if import imhq_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic [1:0]                    action;
    logic [ID_W-1:0]               item_id;
    logic signed [EXT_PRIO_W-1:0]  priority_req;

    modport source (output valid, action, item_id, priority_req, input ready);
    modport sink (input valid, action, item_id, priority_req, output ready);
endinterface

interface imhq_rsp_if import imhq_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic [2:0]                    status;
    logic [ID_W-1:0]               top_id;
    logic signed [EXT_PRIO_W-1:0]  top_priority;
    logic [CNT_OUT_W-1:0]          entry_count;

    modport source (output valid, status, top_id, top_priority, entry_count, input ready);
    modport sink (input valid, status, top_id, top_priority, entry_count, output ready);
endinterface

// File: hdl/imhq_heap_ram.sv
module imhq_heap_ram import imhq_pkg::*; #(
    parameter int DEPTH = DEF_DEPTH,
    parameter int WIDTH = ID_W + DEF_PRIO_W
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

// File: hdl/imhq_map.sv
module imhq_map import imhq_pkg::*; #(
    parameter int DEPTH = DEF_DEPTH
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_we,
    input  logic [ID_W-1:0]          i_waddr,
    input  logic [$clog2(DEPTH)-1:0] i_wdata,
    input  logic                     i_clr,
    input  logic [ID_W-1:0]          i_clr_id,
    input  logic [ID_W-1:0]          i_raddr,
    output logic [$clog2(DEPTH)-1:0] o_rdata,
    input  logic [ID_W-1:0]          i_qid,
    output logic                     o_queued
);

    localparam int SW = $clog2(DEPTH);

    logic [SW-1:0]       mem [ID_COUNT];
    logic [ID_COUNT-1:0] r_valid;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (i_we) begin
                r_valid[i_waddr] <= 1'b1;
            end
            if (i_clr) begin
                r_valid[i_clr_id] <= 1'b0;
            end
        end
    end

    assign o_queued = r_valid[i_qid];

endmodule

// File: hdl/indexed_max_heap_queue_core.sv
// indexed max-heap priority queue
// request channel i_req: action (push, pop max, update), item_id, priority_req
// response channel o_rsp: one response per request with status, top_id,
// top_priority and entry_count after the request
// i_cfg_wr_en / i_cfg_wr_data set the capacity limit, write only while idle
// one request is in flight at a time; i_req.ready is high only when idle
// heap slots live in a one-port-read sync ram, the id to slot map in a second
// sync ram with a valid flop per id; each sift level costs a heap read and a
// compare. Errors and action 3 go straight to the response; a push sifts up,
// a pop reads the top and the last slot, then sifts down, and an update reads
// the item's slot from the map, then sifts up or down
// the response sits in an output register; a new request is taken while it
// waits, and the next response waits until the register is free
// reset empties the queue and sets the capacity limit to 64
module indexed_max_heap_queue_core import imhq_pkg::*; #(
    parameter int DEPTH      = DEF_DEPTH,
    parameter int PRIO_WIDTH = DEF_PRIO_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [CAP_W-1:0] i_cfg_wr_data,
    imhq_req_if.sink         i_req,
    imhq_rsp_if.source       o_rsp
);

    localparam int SW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int LW = (CW > CAP_W) ? CW : CAP_W;
    localparam int XW = SW + 2;
    localparam int PW = PRIO_WIDTH;
    localparam int EW = ID_W + PW;

    t_state                r_state, n_state;
    logic [ID_W-1:0]       r_id, n_id;
    logic signed [PW-1:0]  r_prio, n_prio;
    logic [SW-1:0]         r_pos, n_pos;
    logic [ID_W-1:0]       r_cur_id, n_cur_id;
    logic signed [PW-1:0]  r_cur_prio, n_cur_prio;
    logic [ID_W-1:0]       r_l_id, n_l_id;
    logic signed [PW-1:0]  r_l_prio, n_l_prio;
    logic [ID_W-1:0]       r_top_id, n_top_id;
    logic signed [PW-1:0]  r_top_prio, n_top_prio;
    t_status               r_status, n_status;
    logic [CW-1:0]         r_count, n_count;
    logic [CAP_W-1:0]      r_cap;

    logic                  r_rsp_valid, n_rsp_valid;
    t_status               r_rsp_status, n_rsp_status;
    logic [ID_W-1:0]       r_rsp_top_id, n_rsp_top_id;
    logic signed [PW-1:0]  r_rsp_top_prio, n_rsp_top_prio;
    logic [CW-1:0]         r_rsp_count, n_rsp_count;

    logic                  heap_we;
    logic [SW-1:0]         heap_waddr, heap_raddr;
    logic [EW-1:0]         heap_wdata, heap_rdata;
    logic                  map_we, map_clr, queued;
    logic [ID_W-1:0]       map_waddr;
    logic [SW-1:0]         map_wdata, map_rdata;

    logic [ID_W-1:0]       rd_id;
    logic signed [PW-1:0]  rd_prio, req_prio, best_lc;
    logic [XW-1:0]         left_ix, right_ix, count_x;
    logic [SW-1:0]         parent_ix, last_ix;
    logic [LW-1:0]         limit;
    logic                  req_fire, l_gt_cur;

    imhq_heap_ram #(.DEPTH(DEPTH), .WIDTH(EW)) u_heap (
        .i_clk   (i_clk),
        .i_we    (heap_we),
        .i_waddr (heap_waddr),
        .i_wdata (heap_wdata),
        .i_raddr (heap_raddr),
        .o_rdata (heap_rdata)
    );

    imhq_map #(.DEPTH(DEPTH)) u_map (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_we     (map_we),
        .i_waddr  (map_waddr),
        .i_wdata  (map_wdata),
        .i_clr    (map_clr),
        .i_clr_id (r_top_id),
        .i_raddr  (i_req.item_id),
        .o_rdata  (map_rdata),
        .i_qid    (i_req.item_id),
        .o_queued (queued)
    );

    assign rd_id     = heap_rdata[EW-1:PW];
    assign rd_prio   = signed'(heap_rdata[PW-1:0]);
    assign req_prio  = PW'(i_req.priority_req);
    assign left_ix   = XW'({r_pos, 1'b1});
    assign right_ix  = left_ix + XW'(1);
    assign count_x   = XW'(r_count);
    assign parent_ix = (r_pos - SW'(1)) >> 1;
    assign last_ix   = SW'(r_count - CW'(1));
    assign limit     = (LW'(r_cap) > LW'(DEPTH)) ? LW'(DEPTH) : LW'(r_cap);
    assign req_fire  = i_req.valid && i_req.ready;
    assign l_gt_cur  = r_l_prio > r_cur_prio;
    assign best_lc   = l_gt_cur ? r_l_prio : r_cur_prio;

    assign o_rsp.valid        = r_rsp_valid;
    assign o_rsp.status       = r_rsp_status;
    assign o_rsp.top_id       = r_rsp_top_id;
    assign o_rsp.top_priority = EXT_PRIO_W'(r_rsp_top_prio);
    assign o_rsp.entry_count  = CNT_OUT_W'(r_rsp_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_cap       <= CAP_W'(CAP_RESET);
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_rsp_valid <= n_rsp_valid;
            if (i_cfg_wr_en) begin
                r_cap <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_id           <= n_id;
        r_prio         <= n_prio;
        r_pos          <= n_pos;
        r_cur_id       <= n_cur_id;
        r_cur_prio     <= n_cur_prio;
        r_l_id         <= n_l_id;
        r_l_prio       <= n_l_prio;
        r_top_id       <= n_top_id;
        r_top_prio     <= n_top_prio;
        r_status       <= n_status;
        r_rsp_status   <= n_rsp_status;
        r_rsp_top_id   <= n_rsp_top_id;
        r_rsp_top_prio <= n_rsp_top_prio;
        r_rsp_count    <= n_rsp_count;
    end

    always_comb begin
        n_state        = r_state;
        n_id           = r_id;
        n_prio         = r_prio;
        n_pos          = r_pos;
        n_cur_id       = r_cur_id;
        n_cur_prio     = r_cur_prio;
        n_l_id         = r_l_id;
        n_l_prio       = r_l_prio;
        n_top_id       = r_top_id;
        n_top_prio     = r_top_prio;
        n_status       = r_status;
        n_count        = r_count;
        n_rsp_valid    = r_rsp_valid && !o_rsp.ready;
        n_rsp_status   = r_rsp_status;
        n_rsp_top_id   = r_rsp_top_id;
        n_rsp_top_prio = r_rsp_top_prio;
        n_rsp_count    = r_rsp_count;
        i_req.ready    = 1'b0;
        heap_we        = 1'b0;
        heap_waddr     = r_pos;
        heap_wdata     = {r_cur_id, r_cur_prio};
        heap_raddr     = '0;
        map_we         = 1'b0;
        map_waddr      = r_cur_id;
        map_wdata      = r_pos;
        map_clr        = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                i_req.ready = 1'b1;
                if (req_fire) begin
                    n_id       = i_req.item_id;
                    n_prio     = req_prio;
                    n_top_id   = '0;
                    n_top_prio = '0;
                    n_status   = STAT_OK;
                    n_state    = S_DONE;
                    unique case (t_action'(i_req.action))
                        ACT_PUSH: begin
                            if (LW'(r_count) >= limit) begin
                                n_status = STAT_FULL;
                            end else if (queued) begin
                                n_status = STAT_DUP;
                            end else begin
                                n_pos      = SW'(r_count);
                                n_cur_id   = i_req.item_id;
                                n_cur_prio = req_prio;
                                n_count    = r_count + CW'(1);
                                n_state    = S_UP;
                            end
                        end
                        ACT_POP: begin
                            if (r_count == '0) begin
                                n_status = STAT_EMPTY;
                            end else begin
                                n_state = S_POP0;
                            end
                        end
                        ACT_UPDATE: begin
                            if (!queued) begin
                                n_status = STAT_MISSING;
                            end else begin
                                n_state = S_UPD0;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_POP0: begin
                n_top_id   = rd_id;
                n_top_prio = rd_prio;
                heap_raddr = last_ix;
                n_count    = r_count - CW'(1);
                n_state    = S_POP1;
            end
            S_POP1: begin
                n_cur_id   = rd_id;
                n_cur_prio = rd_prio;
                map_clr    = 1'b1;
                n_pos      = '0;
                n_state    = (r_count == '0) ? S_DONE : S_DN;
            end
            S_UPD0: begin
                heap_raddr = map_rdata;
                n_pos      = map_rdata;
                n_state    = S_UPD1;
            end
            S_UPD1: begin
                n_cur_id   = r_id;
                n_cur_prio = r_prio;
                n_state    = (r_prio > rd_prio) ? S_UP : S_DN;
            end
            S_UP: begin
                heap_raddr = parent_ix;
                n_state    = (r_pos == '0) ? S_PLACE : S_UP_CMP;
            end
            S_UP_CMP: begin
                if (r_cur_prio > rd_prio) begin
                    heap_we    = 1'b1;
                    heap_wdata = heap_rdata;
                    map_we     = 1'b1;
                    map_waddr  = rd_id;
                    n_pos      = parent_ix;
                    n_state    = S_UP;
                end else begin
                    n_state = S_PLACE;
                end
            end
            S_DN: begin
                heap_raddr = left_ix[SW-1:0];
                n_state    = (left_ix >= count_x) ? S_PLACE : S_DN_L;
            end
            S_DN_L: begin
                n_l_id   = rd_id;
                n_l_prio = rd_prio;
                if (right_ix < count_x) begin
                    heap_raddr = right_ix[SW-1:0];
                    n_state    = S_DN_R;
                end else if (rd_prio > r_cur_prio) begin
                    heap_we    = 1'b1;
                    heap_wdata = heap_rdata;
                    map_we     = 1'b1;
                    map_waddr  = rd_id;
                    n_pos      = left_ix[SW-1:0];
                    n_state    = S_DN;
                end else begin
                    n_state = S_PLACE;
                end
            end
            S_DN_R: begin
                if (rd_prio > best_lc) begin
                    heap_we    = 1'b1;
                    heap_wdata = heap_rdata;
                    map_we     = 1'b1;
                    map_waddr  = rd_id;
                    n_pos      = right_ix[SW-1:0];
                    n_state    = S_DN;
                end else if (l_gt_cur) begin
                    heap_we    = 1'b1;
                    heap_wdata = {r_l_id, r_l_prio};
                    map_we     = 1'b1;
                    map_waddr  = r_l_id;
                    n_pos      = left_ix[SW-1:0];
                    n_state    = S_DN;
                end else begin
                    n_state = S_PLACE;
                end
            end
            S_PLACE: begin
                heap_we = 1'b1;
                map_we  = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_rsp_valid || o_rsp.ready) begin
                    n_rsp_valid    = 1'b1;
                    n_rsp_status   = r_status;
                    n_rsp_top_id   = r_top_id;
                    n_rsp_top_prio = r_top_prio;
                    n_rsp_count    = r_count;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// File: hdl/imhq_checker.sv
module imhq_checker import imhq_pkg::*; (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_req_valid,
    input logic                         i_req_ready,
    input logic                         i_rsp_valid,
    input logic                         i_rsp_ready,
    input logic [2:0]                   i_rsp_status,
    input logic [ID_W-1:0]              i_rsp_top_id,
    input logic signed [EXT_PRIO_W-1:0] i_rsp_top_priority,
    input logic [CNT_OUT_W-1:0]         i_rsp_entry_count
);

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request taken while another is in flight");

    a_error_zero_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_status != STAT_OK |-> i_rsp_top_id == '0
            && i_rsp_top_priority == '0)
        else $error("failed request reports a popped entry");

    a_top_needs_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_top_id != '0 |-> i_rsp_status == STAT_OK)
        else $error("popped id with error status");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_status)
            && $stable(i_rsp_entry_count) && $stable(i_rsp_top_id))
        else $error("stalled response changed");

endmodule

bind indexed_max_heap_queue_core imhq_checker u_imhq_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_req_valid        (i_req.valid),
    .i_req_ready        (i_req.ready),
    .i_rsp_valid        (o_rsp.valid),
    .i_rsp_ready        (o_rsp.ready),
    .i_rsp_status       (o_rsp.status),
    .i_rsp_top_id       (o_rsp.top_id),
    .i_rsp_top_priority (o_rsp.top_priority),
    .i_rsp_entry_count  (o_rsp.entry_count)
);

// File: bench/tb_queue_model.sv
package tb_queue_model_pkg;
    import imhq_pkg::*;

    typedef struct packed {
        logic [2:0]        status;
        logic [ID_W-1:0]   top_id;
        logic [31:0]       top_priority;
        logic [6:0]        entry_count;
    } t_heap_rsp;

    class heap_scoreboard;
        logic [ID_W-1:0]    heap_id [64];
        logic signed [31:0] heap_prio [64];
        int                 id_pos [64];
        bit                 id_live [64];
        int                 count;
        int                 cap_limit;
        t_heap_rsp          pending [$];
        int                 errors;

        function new();
            count = 0;
            cap_limit = CAP_RESET;
            errors = 0;
            foreach (id_live[i]) id_live[i] = 0;
        endfunction

        function void swap_slots(int a, int b);
            logic [ID_W-1:0]    ti;
            logic signed [31:0] tp;
            ti = heap_id[a];
            tp = heap_prio[a];
            heap_id[a] = heap_id[b];
            heap_prio[a] = heap_prio[b];
            heap_id[b] = ti;
            heap_prio[b] = tp;
            id_pos[heap_id[a]] = a;
            id_pos[heap_id[b]] = b;
        endfunction

        function void sift_up(int p);
            int par;
            while (p > 0) begin
                par = (p - 1) / 2;
                if (heap_prio[p] <= heap_prio[par]) break;
                swap_slots(p, par);
                p = par;
            end
        endfunction

        function void sink_slot(int p);
            int best;
            while (p < count) begin
                best = p;
                if (2*p+1 < count && heap_prio[2*p+1] > heap_prio[best]) best = 2*p+1;
                if (2*p+2 < count && heap_prio[2*p+2] > heap_prio[best]) best = 2*p+2;
                if (best == p) break;
                swap_slots(p, best);
                p = best;
            end
        endfunction

        function void note_request(t_action act, logic [ID_W-1:0] id,
                                   logic signed [31:0] prio);
            t_heap_rsp r;
            int lim;
            logic signed [31:0] old;
            r = '0;
            lim = cap_limit < 64 ? cap_limit : 64;
            case (act)
                ACT_PUSH: begin
                    if (count >= lim) r.status = STAT_FULL;
                    else if (id_live[id]) r.status = STAT_DUP;
                    else begin
                        heap_id[count] = id;
                        heap_prio[count] = prio;
                        id_pos[id] = count;
                        id_live[id] = 1;
                        count++;
                        sift_up(count - 1);
                    end
                end
                ACT_POP: begin
                    if (count == 0) r.status = STAT_EMPTY;
                    else begin
                        r.top_id = heap_id[0];
                        r.top_priority = heap_prio[0];
                        heap_id[0] = heap_id[count-1];
                        heap_prio[0] = heap_prio[count-1];
                        id_pos[heap_id[0]] = 0;
                        count--;
                        id_live[r.top_id] = 0;
                        sink_slot(0);
                    end
                end
                ACT_UPDATE: begin
                    if (!id_live[id]) r.status = STAT_MISSING;
                    else begin
                        old = heap_prio[id_pos[id]];
                        heap_prio[id_pos[id]] = prio;
                        if (prio > old) sift_up(id_pos[id]);
                        else sink_slot(id_pos[id]);
                    end
                end
                default: ;
            endcase
            r.entry_count = 7'(count);
            pending.push_back(r);
        endfunction

        function void check_response(t_heap_rsp got);
            t_heap_rsp exp;
            if (pending.size() == 0) begin
                $display("%0t unexpected response %h", $time, got);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.status !== exp.status) begin
                $display("%0t status exp %0d got %0d", $time, exp.status, got.status);
                errors++;
            end
            if (got.top_id !== exp.top_id) begin
                $display("%0t top_id exp %0d got %0d", $time, exp.top_id, got.top_id);
                errors++;
            end
            if (got.top_priority !== exp.top_priority) begin
                $display("%0t top_priority exp %h got %h", $time, exp.top_priority,
                         got.top_priority);
                errors++;
            end
            if (got.entry_count !== exp.entry_count) begin
                $display("%0t entry_count exp %0d got %0d", $time, exp.entry_count,
                         got.entry_count);
                errors++;
            end
        endfunction
    endclass
endpackage

// File: bench/tb.sv
module tb;
    import imhq_pkg::*;
    import tb_queue_model_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_wr_en;
    logic [CAP_W-1:0] i_cfg_wr_data;
    int               send_idle_pct;
    int               recv_stall_pct;
    int               hold_off;
    int               cycles;
    heap_scoreboard   sb;

    imhq_req_if req_if ();
    imhq_rsp_if rsp_if ();

    indexed_max_heap_queue_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_req         (req_if.sink),
        .o_rsp         (rsp_if.source)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    initial begin
        sb = new();
        i_rst_n = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_wr_data = '0;
        req_if.valid = 1'b0;
        req_if.action = '0;
        req_if.item_id = '0;
        req_if.priority_req = '0;
        rsp_if.ready = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off = 0;
        cycles = 0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 2000000) begin
            $display("status: fail");
            $finish;
        end
    end

    // receiver with random stalls and a single long hold-off
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready)
            sb.check_response({rsp_if.status, rsp_if.top_id, rsp_if.top_priority,
                               rsp_if.entry_count});
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= i_rst_n && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_request(t_action act, logic [ID_W-1:0] id, logic [31:0] prio);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.action <= act;
        req_if.item_id <= id;
        req_if.priority_req <= prio;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        sb.note_request(act, id, prio);
    endtask

    task automatic drain_and_config(logic [6:0] lim);
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= lim;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        sb.cap_limit = lim;
    endtask

    function automatic logic [31:0] rand_prio();
        case ($urandom_range(5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom_range(3) << 16;
            default: return $urandom;
        endcase
    endfunction

    task automatic random_phase(int n);
        int r;
        t_action act;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(99);
            if (r < 45) act = ACT_PUSH;
            else if (r < 75) act = ACT_POP;
            else if (r < 97) act = ACT_UPDATE;
            else act = ACT_NONE;
            send_request(act, ID_W'($urandom_range(63)), rand_prio());
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_request(ACT_POP, 6'd0, 32'd0);
        send_request(ACT_UPDATE, 6'd5, 32'd1);
        send_request(ACT_PUSH, 6'd0, 32'h8000_0000);
        send_request(ACT_PUSH, 6'd63, 32'h7FFF_FFFF);
        send_request(ACT_PUSH, 6'd63, 32'd5);
        send_request(ACT_PUSH, 6'd10, 32'h0001_0000);
        send_request(ACT_PUSH, 6'd11, 32'h0001_0000);
        send_request(ACT_PUSH, 6'd12, 32'h0001_0000);
        send_request(ACT_UPDATE, 6'd11, 32'h0001_0000);
        send_request(ACT_UPDATE, 6'd12, 32'h0002_0000);
        send_request(ACT_UPDATE, 6'd63, 32'hFFFF_0000);
        send_request(ACT_NONE, 6'd42, 32'hFFFF_FFFF);
        for (int k = 0; k < 7; k++) send_request(ACT_POP, 6'd0, 32'd0);
        drain_and_config(7'd1);
        send_request(ACT_PUSH, 6'd1, 32'd3);
        send_request(ACT_PUSH, 6'd2, 32'd4);
        drain_and_config(7'd0);
        send_request(ACT_PUSH, 6'd3, 32'd4);
        send_request(ACT_POP, 6'd0, 32'd0);
        drain_and_config(7'd64);
        // long receiver hold-off while requests keep coming
        hold_off = 400;
        random_phase(60);
        drain_and_config(7'd127);
        random_phase(300);
        send_idle_pct = 56;
        drain_and_config(7'd8);
        random_phase(250);
        send_idle_pct = 0;
        recv_stall_pct = 56;
        drain_and_config(7'd64);
        random_phase(350);
        send_idle_pct = 30;
        recv_stall_pct = 30;
        drain_and_config(7'd3);
        random_phase(120);
        drain_and_config(7'd40);
        random_phase(250);
        req_if.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

// File: sim.f
hdl/imhq_pkg.sv
hdl/imhq_if.sv
hdl/imhq_heap_ram.sv
hdl/imhq_map.sv
hdl/indexed_max_heap_queue_core.sv
hdl/imhq_checker.sv
bench/tb_queue_model.sv
bench/tb.sv
